// ===== hdl/ndcu_pkg.sv =====
// shared constants and types for the unproject-to-view pipeline
package ndcu_pkg;

   localparam int IN_W      = 17;                        // screen and depth fields, unsigned Q1.16
   localparam int IN_FRAC   = 16;                        // fraction bits of the input fields
   localparam int NDC_W     = IN_W + 2;                  // signed 2*s-1, reaches nearly 3.0
   localparam int OUT_W     = 32;                        // view-space components
   localparam int INT_BITS  = 32;                        // integer quotient bits before overflow
   localparam int NUM_LANES = 3;                         // x, y and z
   localparam int FRONT_LAT = 5;                         // ndc, multiply, two adds, magnitude
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 64;
   localparam int REQ_W     = ((NUM_LANES * IN_W + 7) / 8) * 8;
   localparam int RSP_W     = NUM_LANES * OUT_W;
   localparam int USER_W    = 2;
   localparam int TUSER_DEGEN = 0;
   localparam int TUSER_OVF   = 1;

   localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

   typedef struct packed {
      logic [OUT_W-1:0] value;
      logic             sat;
   } lane_res_type;

endpackage

// ===== hdl/ndc_unproject_to_view.sv =====
// unproject screen coordinates and depth to view space through an inverse projection matrix
//
// req_ carries one pixel per transaction: screen u, v and depth, unsigned Q1.16.
// each is mapped to device coordinates (2s-1), multiplied by the column-major
// 4x4 matrix held in the csr_ registers, and x, y, z are divided by w.
// rsp_ returns view x, y, z as signed Q16.16 (FRAC_BITS fraction bits), rounded
// to nearest with ties away from zero and saturated; tuser flags a zero w (raw
// x, y, z rounded, no divide) and saturation of any component.
// csr_ writes register i at any edge with csr_we high outside reset; register 2c+h holds
// column c, rows 2h (bits 31:0) and 2h+1 (bits 63:32); write only while idle.
// throughput: one transaction per cycle in and out while rsp_ is not stalled.
// the divider resolves one quotient bit per pipeline stage.
// reset clears every valid bit and reloads the identity matrix.
// when rsp_ is stalled the whole pipeline holds and req_tready drops, so
// nothing is dropped or repeated; a bubble still lets the pipeline move.
module ndc_unproject_to_view #(
   parameter int FRAC_BITS  = 16,
   parameter int COEF_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ndcu_pkg::REQ_W-1:0]     req_tdata,   // screen_u, screen_v, depth_sample, zero fill
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ndcu_pkg::RSP_W-1:0]     rsp_tdata,   // view_x, view_y, view_z
   output logic [ndcu_pkg::USER_W-1:0]    rsp_tuser,   // degenerate, overflow
   input  logic                           csr_we,
   input  logic [ndcu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ndcu_pkg::CSR_W-1:0]     csr_wdata
);
   import ndcu_pkg::*;

   localparam int PROD_W    = COEF_WIDTH + NDC_W;
   localparam int ACC_W     = PROD_W + 2;
   // wide enough for the product sums and for the zero-w divisor 2^(16+FRAC_BITS)
   localparam int MAG_W     = (ACC_W > IN_FRAC + FRAC_BITS + 1) ? ACC_W
                                                               : IN_FRAC + FRAC_BITS + 1;
   localparam int DIV_STEPS = INT_BITS + 1 + FRAC_BITS;
   localparam int LANE_LAT  = DIV_STEPS + 3;
   localparam int PIPE_LAT  = FRONT_LAT + LANE_LAT;

   localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(64'd1 << FRAC_BITS);
   localparam logic signed [NDC_W-1:0] NDC_BIAS = NDC_W'(1 << IN_FRAC);
   localparam logic [MAG_W-1:0] DEG_DIV = MAG_W'(64'd1 << (IN_FRAC + FRAC_BITS));

   // matrix coefficients, [column][row]
   logic signed [COEF_WIDTH-1:0] coef_ff [0:3][0:3];

   // pipeline payload
   logic signed [NDC_W-1:0]  ndc_ff  [0:NUM_LANES-1];
   logic signed [NDC_W-1:0]  ndc_in  [0:NUM_LANES-1];
   logic signed [PROD_W-1:0] prod_ff [0:3][0:3];   // [row][column]
   logic signed [PROD_W-1:0] prod_in [0:3][0:3];
   logic signed [ACC_W-1:0]  pair_ff [0:3][0:1];
   logic signed [ACC_W-1:0]  pair_in [0:3][0:1];
   logic signed [ACC_W-1:0]  sum_ff  [0:3];
   logic signed [ACC_W-1:0]  sum_in  [0:3];
   logic [ACC_W-1:0]         abs_v   [0:3];
   logic [MAG_W-1:0]         amag_ff [0:NUM_LANES-1];
   logic [MAG_W-1:0]         amag_in [0:NUM_LANES-1];
   logic                     neg_ff  [0:NUM_LANES-1];
   logic                     neg_in  [0:NUM_LANES-1];
   logic [MAG_W-1:0]         bdiv_ff, bdiv_in;
   logic                     deg_ff, deg_in;

   // pipeline control: valid bits and the zero-w flag travel with the data
   logic [PIPE_LAT-1:0] vld_ff, vld_in;
   logic [LANE_LAT-1:0] dgn_ff, dgn_in;
   logic                pipe_en;
   lane_res_type        lane_res [0:NUM_LANES-1];

   // whole pipeline advances unless a finished result is waiting
   assign pipe_en    = !rsp_tvalid || rsp_tready;
   assign req_tready = pipe_en;

   // csr writes: index bits 2:1 pick the column, bit 0 the row pair
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
               coef_ff[c][r] <= (c == r) ? COEF_ONE : '0;
            end
         end
      end else if (csr_we) begin
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
               if (csr_index[2:1] == 2'(c) && csr_index[0] == r[1]) begin
                  coef_ff[c][r] <= r[0] ? csr_wdata[32 +: COEF_WIDTH]
                                        : csr_wdata[COEF_WIDTH-1:0];
               end
            end
         end
      end
   end

   always_comb begin
      // stage 1: device coordinates, exact in Q.16
      for (int i = 0; i < NUM_LANES; i++) begin
         ndc_in[i] = $signed({1'b0, req_tdata[i*IN_W +: IN_W], 1'b0}) - NDC_BIAS;
      end
      // stage 2: one multiplier per x, y and z coefficient; the w input is 1.0, a shift
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < NUM_LANES; c++) begin
            prod_in[r][c] = PROD_W'(coef_ff[c][r]) * PROD_W'(ndc_ff[c]);
         end
         prod_in[r][3] = PROD_W'(coef_ff[3][r]) <<< IN_FRAC;
      end
      // stages 3 and 4: exact row sums, two adds deep
      for (int r = 0; r < 4; r++) begin
         pair_in[r][0] = ACC_W'(prod_ff[r][0]) + ACC_W'(prod_ff[r][1]);
         pair_in[r][1] = ACC_W'(prod_ff[r][2]) + ACC_W'(prod_ff[r][3]);
         sum_in[r]     = pair_ff[r][0] + pair_ff[r][1];
      end
      // stage 5: sign and magnitude for the dividers
      for (int r = 0; r < 4; r++) begin
         abs_v[r] = sum_ff[r][ACC_W-1] ? ACC_W'(-sum_ff[r]) : sum_ff[r];
      end
      deg_in = (sum_ff[3] == '0);
      // zero w: dividing by 2^(16+FRAC_BITS) gives the raw value rounded to
      // FRAC_BITS fraction bits, through the same rounding and saturation
      bdiv_in = deg_in ? DEG_DIV : MAG_W'(abs_v[3]);
      for (int i = 0; i < NUM_LANES; i++) begin
         amag_in[i] = MAG_W'(abs_v[i]);
         neg_in[i]  = sum_ff[i][ACC_W-1] ^ sum_ff[3][ACC_W-1];
      end
      vld_in = {vld_ff[PIPE_LAT-2:0], req_tvalid};
      dgn_in = {dgn_ff[LANE_LAT-2:0], deg_ff};
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         ndc_ff  <= ndc_in;
         prod_ff <= prod_in;
         pair_ff <= pair_in;
         sum_ff  <= sum_in;
         amag_ff <= amag_in;
         neg_ff  <= neg_in;
         bdiv_ff <= bdiv_in;
         deg_ff  <= deg_in;
         dgn_ff  <= dgn_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= vld_in;
      end
   end

   // one divider lane per component, all sharing the divisor (w magnitude, or DEG_DIV for zero w)
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      ndcu_lane #(
         .FRAC_BITS (FRAC_BITS),
         .MAG_W     (MAG_W)
      ) u_lane (
         .clock    (clock),
         .adv      (pipe_en),
         .dividend (amag_ff[g]),
         .divisor  (bdiv_ff),
         .neg      (neg_ff[g]),
         .res      (lane_res[g])
      );
   end

   assign rsp_tvalid = vld_ff[PIPE_LAT-1];
   assign rsp_tdata  = {lane_res[2].value, lane_res[1].value, lane_res[0].value};
   assign rsp_tuser[TUSER_DEGEN] = dgn_ff[LANE_LAT-1];
   assign rsp_tuser[TUSER_OVF]   = lane_res[0].sat | lane_res[1].sat | lane_res[2].sat;

   // an accepted transaction always occupies the first stage
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted transaction missing from first stage");

   // a stalled pipeline keeps every valid bit in place
   assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");

   // saturation leaves at least one component at a rail
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[TUSER_OVF] |->
         (lane_res[0].value == SAT_POS || lane_res[0].value == SAT_NEG ||
          lane_res[1].value == SAT_POS || lane_res[1].value == SAT_NEG ||
          lane_res[2].value == SAT_POS || lane_res[2].value == SAT_NEG))
      else $error("overflow flagged without a saturated component");

endmodule

// ===== hdl/ndcu_lane.sv =====
// one output component: pipelined restoring divide, rounding, saturation and sign
module ndcu_lane #(
   parameter int FRAC_BITS = 16,
   parameter int MAG_W     = 53
) (
   input  logic                   clock,
   input  logic                   adv,
   input  logic [MAG_W-1:0]       dividend,
   input  logic [MAG_W-1:0]       divisor,
   input  logic                   neg,
   output ndcu_pkg::lane_res_type res
);
   import ndcu_pkg::*;

   localparam int DIV_STEPS = INT_BITS + 1 + FRAC_BITS;
   localparam logic [DIV_STEPS-1:0] LIM_POS = DIV_STEPS'(SAT_POS);
   localparam logic [DIV_STEPS-1:0] LIM_NEG = DIV_STEPS'(SAT_NEG);

   // stage 0 loads the divider, stages 1..DIV_STEPS each yield one quotient bit
   logic [MAG_W-1:0]     rem_ff [0:DIV_STEPS];
   logic [MAG_W-1:0]     rem_in [0:DIV_STEPS];
   logic [MAG_W-1:0]     den_ff [0:DIV_STEPS];
   logic [MAG_W-1:0]     den_in [0:DIV_STEPS];
   logic [INT_BITS-1:0]  low_ff [0:DIV_STEPS];
   logic [INT_BITS-1:0]  low_in [0:DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_ff [0:DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_in [0:DIV_STEPS];
   logic                 sgn_ff [0:DIV_STEPS];
   logic                 sgn_in [0:DIV_STEPS];
   logic                 big_ff [0:DIV_STEPS];
   logic                 big_in [0:DIV_STEPS];
   logic [MAG_W:0]       trial  [1:DIV_STEPS];
   logic                 fits   [1:DIV_STEPS];

   logic [DIV_STEPS:0]   qsum;
   logic [DIV_STEPS-1:0] qrnd;
   logic [OUT_W-1:0]     rmag_ff, rmag_in;
   logic                 rsgn_ff, rsat_ff, rsat_in;
   lane_res_type         res_ff, res_in;

   always_comb begin
      // the high part of the dividend starts the remainder; at or above the divisor
      // the integer quotient would not fit
      rem_in[0] = MAG_W'(dividend[MAG_W-1:INT_BITS]);
      den_in[0] = divisor;
      low_in[0] = dividend[INT_BITS-1:0];
      quo_in[0] = '0;
      sgn_in[0] = neg;
      big_in[0] = MAG_W'(dividend[MAG_W-1:INT_BITS]) >= divisor;
      for (int k = 1; k <= DIV_STEPS; k++) begin
         trial[k]  = {rem_ff[k-1], low_ff[k-1][INT_BITS-1]};
         fits[k]   = trial[k] >= {1'b0, den_ff[k-1]};
         rem_in[k] = fits[k] ? MAG_W'(trial[k] - {1'b0, den_ff[k-1]})
                             : trial[k][MAG_W-1:0];
         den_in[k] = den_ff[k-1];
         low_in[k] = {low_ff[k-1][INT_BITS-2:0], 1'b0};
         quo_in[k] = {quo_ff[k-1][DIV_STEPS-2:0], fits[k]};
         sgn_in[k] = sgn_ff[k-1];
         big_in[k] = big_ff[k-1];
      end
   end

   // quotient carries one extra bit, so half-up on it is round to nearest
   always_comb begin
      qsum    = {1'b0, quo_ff[DIV_STEPS]} + (DIV_STEPS+1)'(1);
      qrnd    = qsum[DIV_STEPS:1];
      rsat_in = big_ff[DIV_STEPS] ||
                (sgn_ff[DIV_STEPS] ? (qrnd > LIM_NEG) : (qrnd > LIM_POS));
      if (rsat_in) begin
         rmag_in = sgn_ff[DIV_STEPS] ? SAT_NEG : SAT_POS;
      end else begin
         rmag_in = qrnd[OUT_W-1:0];
      end
      res_in.value = rsgn_ff ? (~rmag_ff + 1'b1) : rmag_ff;
      res_in.sat   = rsat_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         den_ff  <= den_in;
         low_ff  <= low_in;
         quo_ff  <= quo_in;
         sgn_ff  <= sgn_in;
         big_ff  <= big_in;
         rmag_ff <= rmag_in;
         rsgn_ff <= sgn_ff[DIV_STEPS];
         rsat_ff <= rsat_in;
         res_ff  <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ===== tb/sv/ndc_unproject_to_view_check.sv =====
// checker for the unproject block: predicts each view-space result and compares it
`timescale 1ns / 100ps

module ndc_unproject_to_view_check #(
   parameter int FRAC_BITS  = 16,
   parameter int COEF_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [ndcu_pkg::REQ_W-1:0]     req_tdata,   // screen_u, screen_v, depth_sample, zero fill
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [ndcu_pkg::RSP_W-1:0]     rsp_tdata,   // view_x, view_y, view_z
   input  logic [ndcu_pkg::USER_W-1:0]    rsp_tuser,   // degenerate, overflow
   input  logic                           csr_we,
   input  logic [ndcu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ndcu_pkg::CSR_W-1:0]     csr_wdata,
   output int                             outstanding,
   output int                             mismatches,
   output int                             results_checked,
   output int                             degenerate_hits,
   output int                             saturation_hits
);
   import ndcu_pkg::*;

   typedef struct packed {
      logic [OUT_W-1:0] view_x;
      logic [OUT_W-1:0] view_y;
      logic [OUT_W-1:0] view_z;
      logic             degenerate;
      logic             overflow;
   } view_point_type;

   localparam int NUM_REGS = 1 << CSR_IDX_W;

   logic [CSR_W-1:0] matrix_reg [NUM_REGS];
   view_point_type   views_due [$];

   initial begin
      outstanding     = 0;
      mismatches      = 0;
      results_checked = 0;
      degenerate_hits = 0;
      saturation_hits = 0;
   end

   task automatic flag_mismatch(input string what);
      $display("[%0t] view mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic compare_lane(input string lane, input logic [OUT_W-1:0] got,
                               input logic [OUT_W-1:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s got %h, want %h", lane, got, want));
   endtask

   // signed coefficient at (col, row), sign-extended from COEF_WIDTH bits
   function automatic longint coef_at(input int col, input int row);
      logic [63:0] half;
      logic [63:0] field;
      half  = row[0] ? {32'b0, matrix_reg[2*col + row/2][63:32]}
                     : {32'b0, matrix_reg[2*col + row/2][31:0]};
      field = half << (64 - COEF_WIDTH);
      return $signed(field) >>> (64 - COEF_WIDTH);
   endfunction

   // round(num * 2^FRAC_BITS / den), ties away from zero; huge value when it cannot fit
   function automatic logic [63:0] rounded_quotient(input logic [63:0] num,
                                                    input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      q = num / den;
      r = num % den;
      if (q >= 64'h1_0000_0000)
         return 64'd1 << 40;
      for (int b = 0; b < FRAC_BITS; b++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r    = r - den;
            q[0] = 1'b1;
         end
      end
      r = r << 1;
      if (r >= den)
         q = q + 1;
      return q;
   endfunction

   function automatic view_point_type unproject_pixel(input logic [IN_W-1:0] u,
                                                      input logic [IN_W-1:0] v,
                                                      input logic [IN_W-1:0] d);
      longint           ndc [4];
      longint           hom [4];
      logic [63:0]      mag;
      logic [63:0]      w_mag;
      logic [63:0]      q;
      logic             neg;
      logic             w_neg;
      logic             sat;
      logic [OUT_W-1:0] lane [3];
      view_point_type   res;
      ndc[0] = 2 * longint'(u) - (longint'(1) << IN_FRAC);
      ndc[1] = 2 * longint'(v) - (longint'(1) << IN_FRAC);
      ndc[2] = 2 * longint'(d) - (longint'(1) << IN_FRAC);
      ndc[3] = longint'(1) << IN_FRAC;
      for (int r = 0; r < 4; r++) begin
         hom[r] = 0;
         for (int c = 0; c < 4; c++)
            hom[r] += coef_at(c, r) * ndc[c];
      end
      res.degenerate = (hom[3] == 0);
      sat   = 1'b0;
      w_neg = hom[3] < 0;
      w_mag = w_neg ? -hom[3] : hom[3];
      for (int i = 0; i < 3; i++) begin
         neg = hom[i] < 0;
         mag = neg ? -hom[i] : hom[i];
         if (res.degenerate) begin
            // no divide: just round away the extra input fraction bits
            q = (mag + (64'd1 << (IN_FRAC - 1))) >> IN_FRAC;
         end else begin
            q   = rounded_quotient(mag, w_mag);
            neg = neg ^ w_neg;
         end
         if (neg && q > 64'h8000_0000) begin
            q   = 64'h8000_0000;
            sat = 1'b1;
         end else if (!neg && q > 64'h7FFF_FFFF) begin
            q   = 64'h7FFF_FFFF;
            sat = 1'b1;
         end
         lane[i] = neg ? (~q[OUT_W-1:0] + 1'b1) : q[OUT_W-1:0];
      end
      res.view_x   = lane[0];
      res.view_y   = lane[1];
      res.view_z   = lane[2];
      res.overflow = sat;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      view_point_type got;
      view_point_type want;
      if (reset) begin
         views_due.delete();
         foreach (matrix_reg[i])
            matrix_reg[i] = '0;
         matrix_reg[0] = CSR_W'(1) << FRAC_BITS;
         matrix_reg[2] = CSR_W'(1) << (FRAC_BITS + 32);
         matrix_reg[5] = CSR_W'(1) << FRAC_BITS;
         matrix_reg[7] = CSR_W'(1) << (FRAC_BITS + 32);
      end else begin
         if (csr_we)
            matrix_reg[csr_index] = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            got.view_x     = rsp_tdata[OUT_W-1:0];
            got.view_y     = rsp_tdata[2*OUT_W-1:OUT_W];
            got.view_z     = rsp_tdata[3*OUT_W-1:2*OUT_W];
            got.degenerate = rsp_tuser[TUSER_DEGEN];
            got.overflow   = rsp_tuser[TUSER_OVF];
            if (views_due.size() == 0) begin
               flag_mismatch($sformatf("unexpected result %h", rsp_tdata));
            end else begin
               want = views_due.pop_front();
               compare_lane("view_x", got.view_x, want.view_x);
               compare_lane("view_y", got.view_y, want.view_y);
               compare_lane("view_z", got.view_z, want.view_z);
               if (got.degenerate !== want.degenerate)
                  flag_mismatch($sformatf("degenerate got %b, want %b",
                                          got.degenerate, want.degenerate));
               if (got.overflow !== want.overflow)
                  flag_mismatch($sformatf("overflow got %b, want %b",
                                          got.overflow, want.overflow));
               results_checked++;
               if (want.degenerate)
                  degenerate_hits++;
               if (want.overflow)
                  saturation_hits++;
            end
         end
         if (req_tvalid && req_tready)
            views_due.push_back(unproject_pixel(req_tdata[IN_W-1:0],
                                                req_tdata[2*IN_W-1:IN_W],
                                                req_tdata[3*IN_W-1:2*IN_W]));
      end
      outstanding = views_due.size();
   end

endmodule

// ===== tb/sv/ndc_unproject_to_view_test.sv =====
// top of the unproject testbench: clock, reset, pixel stimulus, matrix loads and verdict
`timescale 1ns / 100ps

module ndc_unproject_to_view_test;
   import ndcu_pkg::*;

   localparam int FRAC_BITS  = 16;
   localparam int COEF_WIDTH = 32;
   localparam int ONE        = 1 << FRAC_BITS;        // 1.0 as a Q16.16 coefficient
   localparam int FILL_W     = REQ_W - NUM_LANES * IN_W;
   localparam int PIPE_LAT   = FRAC_BITS + 41;        // latency given by the block
   localparam int BLOCKS     = 12;
   localparam int BLOCK_LEN  = 50;

   // kinds of matrix loaded before each random block
   typedef enum int {
      MK_IDENTITY,
      MK_PERSPECTIVE,
      MK_SMALL,
      MK_FLAT_W,
      MK_FULL_RANDOM
   } matrix_kind_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic [USER_W-1:0]    rsp_tuser;
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CSR_W-1:0]     csr_wdata  = '0;

   int outstanding;
   int mismatches;
   int results_checked;
   int degenerate_hits;
   int saturation_hits;

   int send_idle_pct = 0;         // chance in a hundred that the sender idles instead of offering the pixel
   int recv_idle_pct = 0;         // chance in a hundred that the receiver drops tready
   int pixels_sent   = 0;
   int settings_done = 0;

   logic [31:0]     coefs [4][4]; // [column][row], signed Q16.16 patterns
   logic [IN_W-1:0] zero_w_depth; // depth at which a perspective matrix gives w == 0, else a random field

   matrix_kind_type block_plan [BLOCKS] = '{
      MK_PERSPECTIVE, MK_FULL_RANDOM, MK_SMALL, MK_FLAT_W,
      MK_PERSPECTIVE, MK_SMALL, MK_FULL_RANDOM, MK_IDENTITY,
      MK_PERSPECTIVE, MK_FLAT_W, MK_SMALL, MK_PERSPECTIVE
   };

   always #4 clock = ~clock;

   ndc_unproject_to_view #(
      .FRAC_BITS  (FRAC_BITS),
      .COEF_WIDTH (COEF_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // watches req_, rsp_ and csr_ and keeps its own copy of the matrix
   ndc_unproject_to_view_check #(
      .FRAC_BITS  (FRAC_BITS),
      .COEF_WIDTH (COEF_WIDTH)
   ) view_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .outstanding     (outstanding),
      .mismatches      (mismatches),
      .results_checked (results_checked),
      .degenerate_hits (degenerate_hits),
      .saturation_hits (saturation_hits)
   );

   // receiver back-pressure, one decision per cycle on the falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // hard stop in case the pipeline locks up
   initial begin
      #2_000_000;
      $display("timeout: %0d transactions still owed by the pipeline", outstanding);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // one pixel transaction; called and left at a falling edge, tvalid kept high after it
   task automatic send_pixel(input logic [IN_W-1:0] u, input logic [IN_W-1:0] v,
                             input logic [IN_W-1:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {{FILL_W{1'b0}}, IN_W'($urandom), IN_W'($urandom), IN_W'($urandom)};
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{FILL_W{1'b0}}, d, v, u};
      do
         @(posedge clock);
      while (!req_tready);
      pixels_sent++;
      @(negedge clock);
   endtask

   // stop sending and wait until every owed result has come back
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0)
         @(negedge clock);
   endtask

   task automatic clear_coefs();
      foreach (coefs[c, r])
         coefs[c][r] = '0;
   endtask

   // register 2c+h carries column c, rows 2h (low word) and 2h+1 (high word)
   task automatic load_coefs();
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= {coefs[i/2][2*(i%2) + 1], coefs[i/2][2*(i%2)]};
         @(negedge clock);
      end
      csr_we <= 1'b0;
      settings_done++;
   endtask

   // mostly in-range coordinates, with range ends, centre and raw 17-bit patterns mixed in
   function automatic logic [IN_W-1:0] random_field();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         case ($urandom_range(3))
            0:       return '0;
            1:       return IN_W'(ONE);
            2:       return IN_W'(ONE / 2);
            default: return '1;
         endcase
      end
      if (pick < 16)
         return IN_W'($urandom);
      return IN_W'($urandom_range(ONE));
   endfunction

   task automatic build_matrix(input matrix_kind_type kind);
      int scale;
      clear_coefs();
      zero_w_depth = random_field();
      case (kind)
         MK_IDENTITY: begin
            for (int i = 0; i < 4; i++)
               coefs[i][i] = ONE;
         end
         MK_PERSPECTIVE: begin
            // inverse of a perspective projection: x and y scaled, a little skew,
            // z fixed at -1 and w linear in depth, crossing zero at zero_w_depth
            coefs[0][0] = $urandom_range(4 * ONE, ONE / 5);
            coefs[1][1] = $urandom_range(4 * ONE, ONE / 5);
            coefs[2][0] = $urandom_range(ONE) - ONE / 2;
            coefs[2][1] = $urandom_range(ONE) - ONE / 2;
            coefs[3][2] = -ONE;
            scale = $urandom_range(4, 1);
            if ($urandom_range(1))
               scale = -scale;
            zero_w_depth = IN_W'($urandom_range(ONE));
            coefs[2][3] = scale * ONE;
            coefs[3][3] = -scale * (2 * int'(zero_w_depth) - ONE);
         end
         MK_SMALL: begin
            foreach (coefs[c, r])
               coefs[c][r] = $urandom_range(4 * ONE) - 2 * ONE;
         end
         MK_FLAT_W: begin
            // w row left at zero, so every pixel takes the no-divide path
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 3; r++)
                  coefs[c][r] = $urandom_range(4 * ONE) - 2 * ONE;
         end
         default: begin
            foreach (coefs[c, r])
               coefs[c][r] = $urandom;
         end
      endcase
      load_coefs();
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 25;
      recv_idle_pct = 51;

      // identity straight out of reset: corners, centre and over-range patterns
      send_pixel('0, '0, '0);
      send_pixel(IN_W'(ONE), IN_W'(ONE), IN_W'(ONE));
      send_pixel(IN_W'(ONE / 2), IN_W'(ONE / 2), IN_W'(ONE / 2));
      send_pixel('1, '1, '1);
      send_pixel(17'h15555, 17'h0AAAA, 17'h00001);
      send_pixel(17'h00001, 17'h0FFFF, 17'h10001);

      // all-zero matrix: w is zero and everything comes out zero
      drain_pipeline();
      clear_coefs();
      load_coefs();
      send_pixel(17'd12345, 17'd54321, 17'd777);

      // extreme coefficients over a tiny w: quotients far beyond range both ways
      drain_pipeline();
      clear_coefs();
      coefs[0][0] = 32'h7FFF_FFFF;
      coefs[1][1] = 32'h8000_0000;
      coefs[2][2] = 32'h7FFF_FFFF;
      for (int r = 0; r < 3; r++)
         coefs[3][r] = 32'h8000_0000;
      coefs[3][3] = 32'h0000_0001;
      load_coefs();
      send_pixel(IN_W'(ONE), '0, '1);
      send_pixel('0, IN_W'(ONE), IN_W'(ONE / 2));
      send_pixel(IN_W'(ONE / 2), IN_W'(ONE / 2), IN_W'(ONE / 2));

      // translation only, w = 1.0: x and y land exactly on the range ends without saturating
      drain_pipeline();
      clear_coefs();
      coefs[3][0] = 32'h8000_0000;
      coefs[3][1] = 32'h7FFF_FFFF;
      coefs[3][2] = 32'hFFFF_FFFF;
      coefs[3][3] = ONE;
      load_coefs();
      send_pixel(IN_W'(ONE / 2), IN_W'(ONE / 2), IN_W'(ONE / 2));
      send_pixel('1, '0, '0);

      // zero w with large raw values: saturation on the no-divide path, ties on y
      drain_pipeline();
      clear_coefs();
      coefs[0][0] = 32'h7FFF_FFFF;
      coefs[1][1] = 32'h0000_0001;
      coefs[2][2] = 32'h8000_0000;
      load_coefs();
      send_pixel('1, IN_W'(3 * ONE / 4), '1);
      send_pixel('0, IN_W'(ONE / 4), '0);

      // w = 2.0 at mid depth gives half-LSB ties; full depth gives w == 0, beyond it w < 0
      drain_pipeline();
      clear_coefs();
      coefs[0][0] = 32'h0000_0001;
      coefs[1][1] = 32'hFFFF_FFFF;
      coefs[2][2] = ONE;
      coefs[2][3] = -2 * ONE;
      coefs[3][3] = 2 * ONE;
      load_coefs();
      send_pixel(IN_W'(ONE), IN_W'(ONE), IN_W'(ONE / 2));
      send_pixel('0, '0, IN_W'(ONE));
      send_pixel('1, '0, '1);

      // every register all ones: each coefficient is minus one LSB
      drain_pipeline();
      foreach (coefs[c, r])
         coefs[c][r] = '1;
      load_coefs();
      send_pixel(IN_W'(ONE / 4), IN_W'(3 * ONE / 4), '1);

      // random blocks, a fresh matrix before each; idling swaps after four blocks, then stops
      for (int blk = 0; blk < BLOCKS; blk++) begin
         if (blk < 4) begin
            send_idle_pct = 25;
            recv_idle_pct = 51;
         end else if (blk < 8) begin
            send_idle_pct = 51;
            recv_idle_pct = 25;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         drain_pipeline();
         build_matrix(block_plan[blk]);
         repeat (BLOCK_LEN) begin
            // one pixel in ten sits on zero_w_depth, where a perspective matrix gives w == 0
            if ($urandom_range(9) == 0)
               send_pixel(random_field(), random_field(), zero_w_depth);
            else
               send_pixel(random_field(), random_field(), random_field());
         end
      end

      drain_pipeline();
      repeat (2 * PIPE_LAT) @(negedge clock);

      $display("%0d pixel transactions under %0d matrix loads, %0d results compared",
               pixels_sent, settings_done, results_checked);
      $display("%0d results with zero w, %0d with a saturated component",
               degenerate_hits, saturation_hits);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== ndc_unproject_to_view.f =====
hdl/ndcu_pkg.sv
hdl/ndcu_lane.sv
hdl/ndc_unproject_to_view.sv
tb/sv/ndc_unproject_to_view_check.sv
tb/sv/ndc_unproject_to_view_test.sv
